// ===== hw/rtl/sfd_pkg.sv =====
`default_nettype none

package sfd_pkg;

  localparam logic [7:0] SOH_BYTE = 8'h01;
  localparam logic [7:0] STX_BYTE = 8'h02;
  localparam logic [7:0] ETX_BYTE = 8'h03;
  localparam logic [7:0] EOT_BYTE = 8'h04;

  localparam logic [7:0] CHECK_VALUE_RESET = 8'h05;

  localparam int          CFG_ADDR_W      = 3;
  localparam int          CFG_DATA_W      = 32;
  localparam logic [2:0] REG_CHECK_VALUE = 3'd0;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_HEADER  = 6'b000010,
    ST_PAYLOAD = 6'b000100,
    ST_CHECK   = 6'b001000,
    ST_EOT     = 6'b010000,
    ST_DELIVER = 6'b100000
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/serial_frame_deframer.sv =====
// latency: a nack or an empty ack is presented the cycle after the byte that causes it
// throughput: one received byte per cycle while parsing, unless a stalled output holds the input
// a good frame delivers its payload from the store one byte at a time (read, then load),
// with the input stalled for the whole burst
// reset: parser returns to idle, header registers clear, check_value becomes 0x05;
// the payload store is not cleared
`default_nettype none

module serial_frame_deframer
  import sfd_pkg::*;
#(
  parameter int MAX_PAYLOAD = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            in_rx_byte,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_verdict,
  output logic      [7:0]            out_source_addr,
  output logic      [7:0]            out_dest_addr,
  output logic      [7:0]            out_payload_byte,
  output logic                       out_byte_valid,
  output logic                       out_last,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int PW_LN = $clog2(MAX_PAYLOAD + 1);
  localparam int PW    = (PW_LN > 2) ? PW_LN : 2;

  state_t          state_r, state_nxt;
  logic [PW-1:0]   pos_r, pos_nxt;
  logic [PW-1:0]   len_r, len_nxt;
  logic [7:0]      from_r, from_nxt;
  logic [7:0]      to_r, to_nxt;
  logic            pend_r, pend_nxt;

  logic            out_valid_r;
  logic            out_verdict_r;
  logic [7:0]      out_source_r;
  logic [7:0]      out_dest_r;
  logic [7:0]      out_byte_r;
  logic            out_bvalid_r;
  logic            out_last_r;

  logic            load;
  logic            res_verdict;
  logic [7:0]      res_byte;
  logic            res_bvalid;
  logic            res_last;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [AW-1:0]   mem_raddr;
  logic [7:0]      mem_rdata;

  logic [7:0]      check_value;
  logic            in_acc;
  logic            out_free;
  logic [7:0]      b;

  sfd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .check_value (check_value)
  );

  sfd_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_rx_byte),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign pready   = 1'b1;
  assign b        = in_rx_byte;
  assign out_free = ~out_valid_r | ~out_stall;
  assign in_stall = (state_r == ST_DELIVER) | (out_valid_r & out_stall);
  assign in_acc   = in_valid & ~in_stall;

  assign mem_waddr = pos_r[AW-1:0];
  assign mem_raddr = pos_r[AW-1:0];

  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    len_nxt     = len_r;
    from_nxt    = from_r;
    to_nxt      = to_r;
    pend_nxt    = pend_r;
    mem_we      = 1'b0;
    load        = 1'b0;
    res_verdict = 1'b0;
    res_byte    = 8'h00;
    res_bvalid  = 1'b0;
    res_last    = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && b == SOH_BYTE) begin
          state_nxt = ST_HEADER;
          pos_nxt   = '0;
        end
      end
      ST_HEADER: begin
        if (in_acc) begin
          if (pos_r == PW'(0)) begin
            from_nxt = b;
            pos_nxt  = PW'(1);
          end else if (pos_r == PW'(1)) begin
            to_nxt  = b;
            pos_nxt = PW'(2);
          end else if (pos_r == PW'(2)) begin
            if (b > 8'(MAX_PAYLOAD)) begin
              state_nxt = ST_IDLE;
              pos_nxt   = '0;
            end else begin
              len_nxt = b[PW-1:0];
              pos_nxt = PW'(3);
            end
          end else if (b == STX_BYTE) begin
            state_nxt = ST_PAYLOAD;
            pos_nxt   = '0;
          end else begin
            state_nxt = ST_IDLE;
            pos_nxt   = '0;
          end
        end
      end
      ST_PAYLOAD: begin
        if (in_acc) begin
          if (pos_r < len_r) begin
            mem_we  = 1'b1;
            pos_nxt = pos_r + PW'(1);
          end else if (b == ETX_BYTE) begin
            state_nxt = ST_CHECK;
          end else begin
            state_nxt = ST_IDLE;
            pos_nxt   = '0;
          end
        end
      end
      ST_CHECK: begin
        if (in_acc) begin
          if (b == check_value) begin
            state_nxt = ST_EOT;
          end else begin
            load      = 1'b1;
            state_nxt = ST_IDLE;
            pos_nxt   = '0;
          end
        end
      end
      ST_EOT: begin
        if (in_acc) begin
          pos_nxt = '0;
          if (b == EOT_BYTE) begin
            if (len_r == '0) begin
              load        = 1'b1;
              res_verdict = 1'b1;
              state_nxt   = ST_IDLE;
            end else begin
              state_nxt = ST_DELIVER;
              pend_nxt  = 1'b0;
            end
          end else begin
            load      = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DELIVER: begin
        if (pend_r) begin
          load        = 1'b1;
          res_verdict = 1'b1;
          res_byte    = mem_rdata;
          res_bvalid  = 1'b1;
          res_last    = (pos_r == len_r);
          pend_nxt    = 1'b0;
          if (pos_r == len_r) begin
            state_nxt = ST_IDLE;
            pos_nxt   = '0;
          end
        end else if (out_free) begin
          pos_nxt  = pos_r + PW'(1);
          pend_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        pos_nxt   = '0;
        pend_nxt  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      len_r       <= '0;
      from_r      <= 8'h00;
      to_r        <= 8'h00;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      len_r       <= len_nxt;
      from_r      <= from_nxt;
      to_r        <= to_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= load | (out_valid_r & out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_verdict_r <= res_verdict;
      out_source_r  <= from_r;
      out_dest_r    <= to_r;
      out_byte_r    <= res_byte;
      out_bvalid_r  <= res_bvalid;
      out_last_r    <= res_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_verdict      = out_verdict_r;
  assign out_source_addr  = out_source_r;
  assign out_dest_addr    = out_dest_r;
  assign out_payload_byte = out_byte_r;
  assign out_byte_valid   = out_bvalid_r;
  assign out_last         = out_last_r;

  // a fetched byte always lands in the output register
  assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |=> out_valid_r)
    else $error("fetched payload byte not presented");

  // burst never runs past the stored length
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DELIVER) |-> (pos_r <= len_r) && (len_r != '0))
    else $error("delivery index out of range");

  // store writes stay within the frame length
  assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (pos_r < len_r) && (len_r <= PW'(MAX_PAYLOAD)))
    else $error("payload write beyond frame length");

endmodule

`default_nettype wire

// ===== hw/rtl/sfd_ram.sv =====
`default_nettype none

module sfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sfd_cfg.sv =====
`default_nettype none

module sfd_cfg
  import sfd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic      [7:0]            check_value
);

  logic [7:0] check_value_r;
  logic [7:0] check_value_nxt;
  logic       wr_en;
  logic       sel_check;

  assign wr_en     = psel & penable & pwrite;
  assign sel_check = (paddr[CFG_ADDR_W-1:2] == REG_CHECK_VALUE[CFG_ADDR_W-1:2]);

  always_comb begin
    check_value_nxt = check_value_r;
    if (wr_en && sel_check) begin
      check_value_nxt = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_value_r <= CHECK_VALUE_RESET;
    end else begin
      check_value_r <= check_value_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_check) begin
      prdata = {{(CFG_DATA_W-8){1'b0}}, check_value_r};
    end
  end

  assign check_value = check_value_r;

endmodule

`default_nettype wire

// ===== tb/sv/serial_frame_deframer_tb.sv =====
`timescale 1ns / 1ps

module serial_frame_deframer_tb;
  import sfd_pkg::*;

  localparam int MAX_FRAME_PAYLOAD = 32;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS = 56;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int N_DIRECTED = 41;

  typedef enum logic [2:0] {
    P_IDLE,
    P_HEADER,
    P_PAYLOAD,
    P_CHECK,
    P_EOT
  } parse_mode_t;

  typedef struct packed {
    logic       verdict;
    logic [7:0] src;
    logic [7:0] dst;
    logic [7:0] data;
    logic       data_ok;
    logic       last;
  } frame_result_t;

  typedef struct packed {
    logic [7:0]    rx;
    logic          typed;
    frame_result_t res;
  } directed_row_t;

  localparam frame_result_t NO_RESULT = '0;
  localparam frame_result_t NACK_BAD_CHECK = '{1'b0, 8'h01, 8'h02, 8'h00, 1'b0, 1'b1};
  localparam frame_result_t ACK_EMPTY = '{1'b1, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b1};
  localparam frame_result_t NACK_NO_EOT = '{1'b0, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b1};

  // length too large, bad stx with soh in its place, bad etx, check mismatch,
  // empty good frame, missing eot
  localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{8'h00, 1'b0, NO_RESULT},
    '{SOH_BYTE, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
    '{8'h21, 1'b0, NO_RESULT},
    '{SOH_BYTE, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT}, '{SOH_BYTE, 1'b0, NO_RESULT},
    '{SOH_BYTE, 1'b0, NO_RESULT}, '{8'h80, 1'b0, NO_RESULT}, '{8'h7F, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, NO_RESULT}, '{STX_BYTE, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT},
    '{SOH_BYTE, 1'b0, NO_RESULT}, '{8'h01, 1'b0, NO_RESULT}, '{8'h02, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT}, '{STX_BYTE, 1'b0, NO_RESULT}, '{ETX_BYTE, 1'b0, NO_RESULT},
    '{8'hFF, 1'b1, NACK_BAD_CHECK},
    '{SOH_BYTE, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, NO_RESULT}, '{STX_BYTE, 1'b0, NO_RESULT}, '{ETX_BYTE, 1'b0, NO_RESULT},
    '{8'h05, 1'b0, NO_RESULT}, '{EOT_BYTE, 1'b1, ACK_EMPTY},
    '{SOH_BYTE, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
    '{8'h01, 1'b0, NO_RESULT}, '{STX_BYTE, 1'b0, NO_RESULT}, '{8'hAA, 1'b0, NO_RESULT},
    '{ETX_BYTE, 1'b0, NO_RESULT}, '{8'h05, 1'b0, NO_RESULT}, '{8'h05, 1'b1, NACK_NO_EOT}
  };

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_rx_byte = 8'h00;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_verdict;
  logic [7:0]            out_source_addr;
  logic [7:0]            out_dest_addr;
  logic [7:0]            out_payload_byte;
  logic                  out_byte_valid;
  logic                  out_last;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  serial_frame_deframer #(.MAX_PAYLOAD(MAX_FRAME_PAYLOAD)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_verdict(out_verdict),
    .out_source_addr(out_source_addr), .out_dest_addr(out_dest_addr),
    .out_payload_byte(out_payload_byte), .out_byte_valid(out_byte_valid),
    .out_last(out_last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // deframer prediction state
  parse_mode_t   rx_mode;
  int unsigned   rx_pos;
  logic [7:0]    hdr_src;
  logic [7:0]    hdr_dst;
  logic [7:0]    hdr_len;
  logic [7:0]    body_bytes [MAX_FRAME_PAYLOAD];
  logic [7:0]    check_byte;
  frame_result_t pending_verdicts [$];

  int unsigned sender_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned phase_items;
  int unsigned fail_count = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    int unsigned n;
    case (rx_mode)
      P_HEADER: begin
        if (rx_pos == 0) begin
          hdr_src = b;
          rx_pos = 1;
        end else if (rx_pos == 1) begin
          hdr_dst = b;
          rx_pos = 2;
        end else if (rx_pos == 2) begin
          hdr_len = b;
          if (b > MAX_FRAME_PAYLOAD) begin
            rx_mode = P_IDLE;
            rx_pos = 0;
          end else begin
            rx_pos = 3;
          end
        end else if (b == STX_BYTE) begin
          rx_mode = P_PAYLOAD;
          rx_pos = 0;
        end else begin
          rx_mode = P_IDLE;
          rx_pos = 0;
        end
      end
      P_PAYLOAD: begin
        if (rx_pos < hdr_len && rx_pos < MAX_FRAME_PAYLOAD) begin
          body_bytes[rx_pos] = b;
          rx_pos++;
        end else if (rx_pos == hdr_len && b == ETX_BYTE) begin
          rx_mode = P_CHECK;
        end else begin
          rx_mode = P_IDLE;
          rx_pos = 0;
        end
      end
      P_CHECK: begin
        if (b == check_byte) begin
          rx_mode = P_EOT;
        end else begin
          pending_verdicts.push_back('{1'b0, hdr_src, hdr_dst, 8'h00, 1'b0, 1'b1});
          rx_mode = P_IDLE;
          rx_pos = 0;
        end
      end
      P_EOT: begin
        if (b == EOT_BYTE) begin
          n = (hdr_len > MAX_FRAME_PAYLOAD) ? MAX_FRAME_PAYLOAD : hdr_len;
          if (n == 0)
            pending_verdicts.push_back('{1'b1, hdr_src, hdr_dst, 8'h00, 1'b0, 1'b1});
          for (int i = 0; i < n; i++)
            pending_verdicts.push_back('{1'b1, hdr_src, hdr_dst, body_bytes[i], 1'b1,
                                         (i + 1 == n)});
        end else begin
          pending_verdicts.push_back('{1'b0, hdr_src, hdr_dst, 8'h00, 1'b0, 1'b1});
        end
        rx_mode = P_IDLE;
        rx_pos = 0;
      end
      default: begin
        if (b == SOH_BYTE) begin
          rx_mode = P_HEADER;
          rx_pos = 0;
        end
      end
    endcase
  endtask

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_byte(input logic [7:0] b, input logic typed, input frame_result_t tres);
    int unsigned n0;
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n0 = pending_verdicts.size();
    deframe_byte(b);
    if (typed) begin
      while (pending_verdicts.size() > n0) void'(pending_verdicts.pop_back());
      pending_verdicts.push_back(tres);
    end
    @(negedge clk);
  endtask

  task automatic send_plain(input logic [7:0] b);
    send_byte(b, 1'b0, NO_RESULT);
    phase_items++;
  endtask

  task automatic write_check_value(input logic [7:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_CHECK_VALUE;
    pwdata <= CFG_DATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_byte = v;
    @(negedge clk);
    if (prdata !== CFG_DATA_W'(v)) begin
      fail_count++;
      if (fail_count <= 10)
        $display("readback mismatch: expected %02h, got %08h", v, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // mostly well-formed frames with random content, some noise and broken frames
  task automatic send_random_frame();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 3)) send_byte(rand_byte(), 1'b0, NO_RESULT);
      return;
    end
    pick = $urandom_range(0, 99);
    if (pick < 5)
      len = MAX_FRAME_PAYLOAD;
    else if (pick < 10)
      len = $urandom_range(MAX_FRAME_PAYLOAD + 1, 255);
    else
      len = $urandom_range(0, 5);
    send_plain(SOH_BYTE);
    send_plain(rand_byte());
    send_plain(rand_byte());
    send_plain(8'(len));
    if (len > MAX_FRAME_PAYLOAD)
      return;
    send_plain(($urandom_range(0, 19) == 0) ? rand_byte() : STX_BYTE);
    repeat (len) send_plain(rand_byte());
    send_plain(($urandom_range(0, 19) == 0) ? rand_byte() : ETX_BYTE);
    send_plain(($urandom_range(0, 7) == 0) ? rand_byte() : check_byte);
    send_plain(($urandom_range(0, 9) == 0) ? rand_byte() : EOT_BYTE);
  endtask

  always @(negedge clk) begin
    static bit hold_taken = 1'b0;
    static int unsigned hold_left = 0;
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    frame_result_t got;
    frame_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_verdict, out_source_addr, out_dest_addr, out_payload_byte,
              out_byte_valid, out_last};
      if (pending_verdicts.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected transaction: v=%0d src=%02h dst=%02h byte=%02h bv=%0d last=%0d",
                   got.verdict, got.src, got.dst, got.data, got.data_ok, got.last);
      end else begin
        want = pending_verdicts.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch: expected v=%0d src=%02h dst=%02h byte=%02h bv=%0d last=%0d",
                     want.verdict, want.src, want.dst, want.data, want.data_ok, want.last);
            $display("          got      v=%0d src=%02h dst=%02h byte=%02h bv=%0d last=%0d",
                     got.verdict, got.src, got.dst, got.data, got.data_ok, got.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    static int unsigned quiet = 0;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned gap_pct [5];
    int unsigned stall_pct [5];
    logic [7:0]  check_sel [5];
    gap_pct = '{0, 66, 0, 14, 0};
    stall_pct = '{0, 0, 66, 14, 0};
    check_sel = '{8'h00, 8'hFF, EOT_BYTE, rand_byte(), CHECK_VALUE_RESET};

    rx_mode = P_IDLE;
    rx_pos = 0;
    hdr_src = 8'h00;
    hdr_dst = 8'h00;
    hdr_len = 8'h00;
    check_byte = CHECK_VALUE_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      send_byte(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);

    for (int p = 0; p < 5; p++) begin
      in_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(negedge clk);
      repeat (8) @(negedge clk);
      sender_gap_pct = gap_pct[p];
      recv_stall_pct = stall_pct[p];
      write_check_value(check_sel[p]);
      // last phase: receiver holds off while frames keep coming
      if (p == 4)
        hold_req = 1'b1;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) send_random_frame();
    end

    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_verdicts.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/sfd_pkg.sv
hw/rtl/sfd_ram.sv
hw/rtl/sfd_cfg.sv
hw/rtl/serial_frame_deframer.sv
tb/sv/serial_frame_deframer_tb.sv
